// File: hdl/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
`timescale 1ns / 1ps

package wsd_pkg;

	// parse phases
	localparam logic [2:0] PH_HDR0    = 3'd0;
	localparam logic [2:0] PH_HDR1    = 3'd1;
	localparam logic [2:0] PH_EXTLEN  = 3'd2;
	localparam logic [2:0] PH_MASK    = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;

	// frame opcodes
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;
	localparam logic [3:0] OP_PONG   = 4'hA;

	// result kinds
	localparam logic [1:0] KIND_TEXT   = 2'd0;
	localparam logic [1:0] KIND_BINARY = 2'd1;
	localparam logic [1:0] KIND_PING   = 2'd2;
	localparam logic [1:0] KIND_CLOSE  = 2'd3;

	// open message codes
	localparam logic [1:0] MSG_NONE = 2'd0;

	// length field escapes
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	typedef struct packed {
		logic       emit;
		logic [7:0] payload_byte;
		logic       byte_valid;
		logic [1:0] kind;
		logic       message_end;
	} wsd_result_t;

endpackage

// File: hdl/wsd_in_reg.sv
// Input register stage: holds one received byte for the parser.
`timescale 1ns / 1ps

module wsd_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       consume,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	assign s_tready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

endmodule

// File: hdl/wsd_parser.sv
// Frame header walker and payload unmasker, one byte per step.
`timescale 1ns / 1ps

module wsd_parser
	import wsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  in_byte,
	output wsd_result_t result
);

	logic [2:0]  phase_q, phase_d;
	logic        fin_q, fin_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        mask_on_q, mask_on_d;
	logic [3:0]  left_q, left_d;
	logic [63:0] remain_q, remain_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  pos_q, pos_d;
	logic [1:0]  msg_q, msg_d;

	logic        hdr_done;
	logic        last;
	logic [7:0]  key_byte;
	logic [7:0]  plain;
	logic [3:0]  left_dec;

	assign left_dec = left_q - 4'd1;

	always_comb begin
		unique case (pos_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	assign plain = mask_on_q ? (in_byte ^ key_byte) : in_byte;
	assign last  = (remain_q == 64'd1);

	always_comb begin
		phase_d   = phase_q;
		fin_d     = fin_q;
		opcode_d  = opcode_q;
		mask_on_d = mask_on_q;
		left_d    = left_q;
		remain_d  = remain_q;
		key_d     = key_q;
		pos_d     = pos_q;
		msg_d     = msg_q;
		hdr_done  = 1'b0;
		result    = '0;

		unique case (phase_q)
			PH_HDR1: begin
				mask_on_d = in_byte[7];
				key_d     = '0;
				remain_d  = '0;
				if (in_byte[6:0] == LEN_EXT16) begin
					left_d  = EXT16_BYTES;
					phase_d = PH_EXTLEN;
				end else if (in_byte[6:0] == LEN_EXT64) begin
					left_d  = EXT64_BYTES;
					phase_d = PH_EXTLEN;
				end else begin
					remain_d = {57'd0, in_byte[6:0]};
					if (in_byte[7]) begin
						left_d  = KEY_BYTES;
						phase_d = PH_MASK;
					end else begin
						hdr_done = 1'b1;
					end
				end
			end
			PH_EXTLEN: begin
				remain_d = {remain_q[55:0], in_byte};
				left_d   = left_dec;
				if (left_dec == 4'd0) begin
					if (mask_on_q) begin
						left_d  = KEY_BYTES;
						phase_d = PH_MASK;
					end else begin
						hdr_done = 1'b1;
					end
				end
			end
			PH_MASK: begin
				key_d  = {key_q[23:0], in_byte};
				left_d = left_dec;
				if (left_dec == 4'd0) begin
					hdr_done = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				pos_d    = pos_q + 2'd1;
				remain_d = remain_q - 64'd1;
				if (last) begin
					phase_d = PH_HDR0;
				end
				priority if (opcode_q == OP_CLOSE) begin
					result.emit        = last;
					result.kind        = KIND_CLOSE;
					result.message_end = 1'b1;
				end else if (opcode_q == OP_PING) begin
					result.emit         = 1'b1;
					result.payload_byte = plain;
					result.byte_valid   = 1'b1;
					result.kind         = KIND_PING;
					result.message_end  = last;
				end else if (opcode_q == OP_PONG) begin
					result.emit = 1'b0;
				end else if (msg_q != MSG_NONE) begin
					result.emit         = 1'b1;
					result.payload_byte = plain;
					result.byte_valid   = 1'b1;
					result.kind         = msg_q - 2'd1;
					result.message_end  = last && fin_q;
					if (last && fin_q) begin
						msg_d = MSG_NONE;
					end
				end else begin
					// data with no open message is dropped
					result.emit = 1'b0;
				end
			end
			default: begin
				// first header byte; unknown phases land here as well
				fin_d    = in_byte[7];
				opcode_d = in_byte[3:0];
				if (in_byte[3:0] == OP_TEXT || in_byte[3:0] == OP_BINARY) begin
					msg_d = in_byte[1:0];
				end
				phase_d = PH_HDR1;
			end
		endcase

		if (hdr_done) begin
			pos_d  = '0;
			left_d = '0;
			if (remain_d == 64'd0) begin
				phase_d = PH_HDR0;
				// frame with no payload completes here
				priority if (opcode_q == OP_CLOSE) begin
					result.emit        = 1'b1;
					result.kind        = KIND_CLOSE;
					result.message_end = 1'b1;
				end else if (opcode_q == OP_PING) begin
					result.emit        = 1'b1;
					result.kind        = KIND_PING;
					result.message_end = 1'b1;
				end else if (opcode_q == OP_PONG) begin
					result.emit = 1'b0;
				end else if (msg_q != MSG_NONE && fin_q) begin
					result.emit        = 1'b1;
					result.kind        = msg_q - 2'd1;
					result.message_end = 1'b1;
					msg_d              = MSG_NONE;
				end else begin
					result.emit = 1'b0;
				end
			end else begin
				phase_d = PH_PAYLOAD;
			end
		end

		if (!step) begin
			result.emit = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR0;
			fin_q     <= 1'b0;
			opcode_q  <= '0;
			mask_on_q <= 1'b0;
			left_q    <= '0;
			remain_q  <= '0;
			key_q     <= '0;
			pos_q     <= '0;
			msg_q     <= MSG_NONE;
		end else if (step) begin
			phase_q   <= phase_d;
			fin_q     <= fin_d;
			opcode_q  <= opcode_d;
			mask_on_q <= mask_on_d;
			left_q    <= left_d;
			remain_q  <= remain_d;
			key_q     <= key_d;
			pos_q     <= pos_d;
			msg_q     <= msg_d;
		end
	end

endmodule

// File: hdl/wsd_out_reg.sv
// Result register toward the master-side stream.
`timescale 1ns / 1ps

module wsd_out_reg
	import wsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  wsd_result_t result,
	output logic        free,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,
	output logic [2:0]  m_tuser,
	output logic        m_tlast
);

	logic        valid_s2;
	wsd_result_t result_s2;
	logic        load;

	assign free = !valid_s2 || m_tready;
	assign load = free && result.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free) begin
			valid_s2 <= result.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = result_s2.payload_byte;
	assign m_tuser  = {result_s2.kind, result_s2.byte_valid};
	assign m_tlast  = result_s2.message_end;

endmodule

// File: hdl/websocket_frame_deframer.sv
// Path: input register, then combinational parser, then result register to the master side.
// Throughput: one byte per cycle unless the result register stalls; one parser step per byte.
// Backpressure: the input register advances whenever the result register is empty or drained.
// Reset: arst_n low clears both stage valids and all parser state at once.
// After reset the parser waits for the first header byte with no message open.
`timescale 1ns / 1ps

module websocket_frame_deframer
	import wsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// slave side: received frame stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] stream_byte
	// master side: unmasked payload and events
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] payload_byte
	output logic [2:0] m_tuser,   // [0] byte_valid, [2:1] kind
	output logic       m_tlast    // message_end
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        free;
	logic        consume;
	wsd_result_t result;

	// A byte leaves the input register whenever the result register can take
	// whatever it produces; bytes with no result still need that slot to be free.
	assign consume = valid_s1 && free;

	wsd_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.consume  (consume),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// Header walk: FIN/opcode, mask bit and length, extended length,
	// mask key, then payload unmasked with key byte (index mod 4).
	wsd_parser u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (consume),
		.in_byte (byte_s1),
		.result  (result)
	);

	wsd_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.result   (result),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// File: hdl/wsd_checker.sv
// Port-level checks for the deframer, bound to the top level.
`timescale 1ns / 1ps

module wsd_checker
	import wsd_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [2:0] m_tuser,
	input logic       m_tlast
);

	// stalled transfer holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	// an empty result slot never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with nothing waiting");

	// an event without data carries a zero byte
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
		else $error("data byte nonzero without byte_valid");

	// an event without data always ends something
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast)
		else $error("dataless result without end mark");

	// close is a pure event
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2:1] == KIND_CLOSE |-> m_tlast && !m_tuser[0])
		else $error("malformed close event");

endmodule

bind websocket_frame_deframer wsd_checker u_chk (.*);

// File: test/websocket_frame_deframer_test.sv
// Testbench for the WebSocket frame deframer: scripted and random byte streams.
`timescale 1ns / 1ps

module websocket_frame_deframer_test;
	import wsd_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int RANDOM_ITEMS = 1500;
	localparam int HOLD_CYCLES  = 150;
	localparam int DRAIN_LIMIT  = 2000;
	localparam int SETTLE_CYCLES = 8;

	// header bits and opcodes the package does not name
	localparam logic       FIN    = 1'b1;
	localparam logic       NOFIN  = 1'b0;
	localparam logic       MASKED = 1'b1;
	localparam logic       PLAIN  = 1'b0;
	localparam logic [3:0] OP_CONT = 4'h0;
	localparam logic [3:0] OP_RSV  = 4'hF;

	// emit = 0: take the prediction; emit = 1: this row carries its own answer
	localparam wsd_result_t FREE          = '0;
	localparam wsd_result_t CLOSE_EVT     = {1'b1, 8'h00, 1'b0, KIND_CLOSE, 1'b1};
	localparam wsd_result_t PING_EMPTY    = {1'b1, 8'h00, 1'b0, KIND_PING, 1'b1};
	localparam wsd_result_t BIN_EMPTY_END = {1'b1, 8'h00, 1'b0, KIND_BINARY, 1'b1};

	typedef struct packed {
		logic [7:0]  data;
		wsd_result_t want;
	} row_t;

	// rows before SCRIPT_SPLIT open the run; the rest close it
	localparam int SCRIPT_SPLIT = 27;
	localparam int SCRIPT_ROWS  = 49;
	localparam row_t SCRIPT [0:SCRIPT_ROWS-1] = '{
		{{FIN, 3'b000, OP_CLOSE}, FREE},       // empty close
		{{PLAIN, 7'd0}, CLOSE_EVT},
		{{FIN, 3'b000, OP_PING}, FREE},        // empty ping
		{{PLAIN, 7'd0}, PING_EMPTY},
		{{FIN, 3'b000, OP_TEXT}, FREE},        // masked text, two bytes
		{{MASKED, 7'd2}, FREE},
		{8'hFF, FREE},
		{8'h00, FREE},
		{8'hA5, FREE},
		{8'h5A, FREE},
		{8'hFF, FREE},
		{8'h12, FREE},
		{{FIN, 3'b000, OP_BINARY}, FREE},      // empty binary ends its own message
		{{PLAIN, 7'd0}, BIN_EMPTY_END},
		{{NOFIN, 3'b000, OP_CONT}, FREE},      // continuation with nothing open
		{{PLAIN, 7'd1}, FREE},
		{8'h55, FREE},
		{{FIN, 3'b000, OP_PONG}, FREE},        // pong is swallowed
		{{PLAIN, 7'd1}, FREE},
		{8'h77, FREE},
		{{NOFIN, 3'b000, OP_TEXT}, FREE},      // empty text fragment, no FIN
		{{PLAIN, 7'd0}, FREE},
		{{FIN, 3'b111, OP_RSV}, FREE},         // reserved opcode closes the text
		{{PLAIN, LEN_EXT16}, FREE},
		{8'h00, FREE},
		{8'h01, FREE},
		{8'hFF, FREE},
		{{FIN, 3'b000, OP_BINARY}, FREE},      // 64-bit length, top bit set
		{{MASKED, LEN_EXT64}, FREE},
		{8'h80, FREE},
		{8'h00, FREE},
		{8'h00, FREE},
		{8'h00, FREE},
		{8'h00, FREE},
		{8'h00, FREE},
		{8'h00, FREE},
		{8'h00, FREE},
		{8'hDE, FREE},
		{8'hAD, FREE},
		{8'hBE, FREE},
		{8'hEF, FREE},
		{8'h00, FREE},
		{8'hFF, FREE},
		{8'h5A, FREE},
		{8'hA5, FREE},
		{8'h12, FREE},
		{8'h34, FREE},
		{8'h80, FREE},
		{8'h7F, FREE}
	};

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // [7:0] stream_byte
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;   // [7:0] payload_byte
	logic [2:0] m_tuser;   // [0] byte_valid, [2:1] kind
	logic       m_tlast;   // message_end

	websocket_frame_deframer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// parser mirror
	logic [2:0]  phase;
	logic        fin;
	logic [3:0]  opcode;
	logic        masked;
	logic [3:0]  hdr_left;
	logic [63:0] remaining;
	logic [31:0] key;
	logic [1:0]  key_pos;
	logic        msg_open;
	logic [1:0]  msg_kind;

	wsd_result_t pending_out[$];
	logic [7:0]  frame_bytes[$];
	int          mismatches = 0;
	int          sent = 0;
	bit          calm = 0;
	bit          hold_req = 0;

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= 100)
			$display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	// header complete: empty frames resolve right here
	function automatic bit close_header(output wsd_result_t r);
		r = '0;
		key_pos = '0;
		hdr_left = '0;
		if (remaining != 0) begin
			phase = PH_PAYLOAD;
			return 1'b0;
		end
		phase = PH_HDR0;
		r.emit = 1'b1;
		r.message_end = 1'b1;
		if (opcode == OP_CLOSE) begin
			r.kind = KIND_CLOSE;
			return 1'b1;
		end
		if (opcode == OP_PING) begin
			r.kind = KIND_PING;
			return 1'b1;
		end
		if (opcode != OP_PONG && msg_open && fin) begin
			r.kind = msg_kind;
			msg_open = 1'b0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// one stream byte in; returns 1 when a result goes out
	function automatic bit deframe_byte(input logic [7:0] b, output wsd_result_t r);
		logic [7:0] plain_byte;
		bit         last;
		r = '0;
		case (phase)
			PH_HDR1: begin
				masked = b[7];
				key = '0;
				remaining = '0;
				if (b[6:0] == LEN_EXT16) begin
					hdr_left = EXT16_BYTES;
					phase = PH_EXTLEN;
				end else if (b[6:0] == LEN_EXT64) begin
					hdr_left = EXT64_BYTES;
					phase = PH_EXTLEN;
				end else begin
					remaining = {57'd0, b[6:0]};
					if (masked) begin
						hdr_left = KEY_BYTES;
						phase = PH_MASK;
					end else begin
						return close_header(r);
					end
				end
				return 1'b0;
			end
			PH_EXTLEN: begin
				remaining = {remaining[55:0], b};
				hdr_left = hdr_left - 4'd1;
				if (hdr_left != 0)
					return 1'b0;
				if (masked) begin
					hdr_left = KEY_BYTES;
					phase = PH_MASK;
					return 1'b0;
				end
				return close_header(r);
			end
			PH_MASK: begin
				key = {key[23:0], b};
				hdr_left = hdr_left - 4'd1;
				if (hdr_left != 0)
					return 1'b0;
				return close_header(r);
			end
			PH_PAYLOAD: begin
				plain_byte = masked ? b ^ key[8 * (3 - key_pos) +: 8] : b;
				key_pos = key_pos + 2'd1;
				remaining = remaining - 64'd1;
				last = (remaining == 0);
				if (last)
					phase = PH_HDR0;
				r.emit = 1'b1;
				if (opcode == OP_CLOSE) begin
					r.kind = KIND_CLOSE;
					r.message_end = 1'b1;
					return last;
				end
				if (opcode == OP_PONG)
					return 1'b0;
				r.payload_byte = plain_byte;
				r.byte_valid = 1'b1;
				if (opcode == OP_PING) begin
					r.kind = KIND_PING;
					r.message_end = last;
					return 1'b1;
				end
				if (!msg_open)
					return 1'b0;
				r.kind = msg_kind;
				r.message_end = last && fin;
				if (r.message_end)
					msg_open = 1'b0;
				return 1'b1;
			end
			default: begin
				// a stray phase code reads as a first header byte
				fin = b[7];
				opcode = b[3:0];
				if (opcode == OP_TEXT) begin
					msg_open = 1'b1;
					msg_kind = KIND_TEXT;
				end else if (opcode == OP_BINARY) begin
					msg_open = 1'b1;
					msg_kind = KIND_BINARY;
				end
				phase = PH_HDR1;
				return 1'b0;
			end
		endcase
	endfunction

	// offer one byte, wait for the transfer, then log what it should produce
	task automatic send_byte(input logic [7:0] b, input wsd_result_t want);
		wsd_result_t r;
		bit          got;
		@(negedge clk);
		while (!calm && $urandom_range(99) < 38) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		got = deframe_byte(b, r);
		if (want.emit)
			pending_out = {pending_out, want};
		else if (got)
			pending_out = {pending_out, r};
		sent++;
	endtask

	// stop offering and let the output side catch up
	task automatic drain();
		int waited;
		@(negedge clk);
		s_tvalid <= 1'b0;
		for (waited = 0; pending_out.size() != 0 && waited < DRAIN_LIMIT; waited++)
			@(posedge clk);
	endtask

	// one frame, mostly well formed, now and then cut short
	task automatic make_frame();
		logic [3:0]  op;
		logic [7:0]  b;
		logic [63:0] len;
		logic        key_on;
		int          pick;
		int          cut;
		frame_bytes.delete();
		pick = $urandom_range(99);
		if (pick < 25)
			op = OP_TEXT;
		else if (pick < 45)
			op = OP_BINARY;
		else if (pick < 60)
			op = OP_CONT;
		else if (pick < 70)
			op = OP_PING;
		else if (pick < 77)
			op = OP_CLOSE;
		else if (pick < 84)
			op = OP_PONG;
		else begin
			op = OP_CONT;
			while (op == OP_CONT || op == OP_TEXT || op == OP_BINARY || op == OP_CLOSE ||
					op == OP_PING || op == OP_PONG)
				op = 4'($urandom_range(15));
		end
		b = 8'($urandom_range(255));   // reserved bits stay random
		b[3:0] = op;
		b[7] = ($urandom_range(99) < 70);
		frame_bytes = {frame_bytes, b};
		key_on = ($urandom_range(99) < 70);

		pick = $urandom_range(99);
		if (pick < 60)
			len = $urandom_range(12);
		else if (pick < 70)
			len = $urandom_range(125, 13);
		else if (pick < 85)
			len = $urandom_range(200);
		else
			len = $urandom_range(40);
		if (pick < 70)
			frame_bytes = {frame_bytes, {key_on, len[6:0]}};
		else if (pick < 85) begin
			frame_bytes = {frame_bytes, {key_on, LEN_EXT16}};
			frame_bytes = {frame_bytes, len[15:8]};
			frame_bytes = {frame_bytes, len[7:0]};
		end else begin
			frame_bytes = {frame_bytes, {key_on, LEN_EXT64}};
			for (int i = 7; i >= 0; i--)
				frame_bytes = {frame_bytes, len[8 * i +: 8]};
		end
		if (key_on)
			repeat (4) frame_bytes = {frame_bytes, 8'($urandom_range(255))};
		repeat (len) frame_bytes = {frame_bytes, 8'($urandom_range(255))};

		// a truncated frame knocks the parser out of step with the framing
		if (frame_bytes.size() > 1 && $urandom_range(99) < 6) begin
			cut = $urandom_range(frame_bytes.size() - 1, 1);
			while (frame_bytes.size() > cut)
				void'(frame_bytes.pop_back());
		end
	endtask

	// output side: random stalls, one long hold-off on request
	initial begin
		bit held;
		held = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				held = 1;
				m_tready <= 1'b0;
				for (int i = 0; i < HOLD_CYCLES; i++)
					@(negedge clk);
			end
			m_tready <= calm || ($urandom_range(99) >= 38);
		end
	end

	// compare each result transfer with the oldest expected one
	always @(posedge clk) begin
		wsd_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_out.size() == 0) begin
				report_mismatch("result with nothing expected", m_tdata, 0);
			end else begin
				want = pending_out.pop_front();
				if (m_tdata !== want.payload_byte)
					report_mismatch("payload_byte", m_tdata, want.payload_byte);
				if (m_tuser[0] !== want.byte_valid)
					report_mismatch("byte_valid", m_tuser[0], want.byte_valid);
				if (m_tuser[2:1] !== want.kind)
					report_mismatch("kind", m_tuser[2:1], want.kind);
				if (m_tlast !== want.message_end)
					report_mismatch("message_end", m_tlast, want.message_end);
			end
		end
	end

	initial begin
		bit paused;
		paused = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		phase = PH_HDR0;
		fin = 1'b0;
		opcode = '0;
		masked = 1'b0;
		hdr_left = '0;
		remaining = '0;
		key = '0;
		key_pos = '0;
		msg_open = 1'b0;
		msg_kind = KIND_TEXT;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < SCRIPT_SPLIT; i++)
			send_byte(SCRIPT[i].data, SCRIPT[i].want);

		while (sent < SCRIPT_SPLIT + RANDOM_ITEMS) begin
			calm = (sent >= SCRIPT_SPLIT + 900 && sent < SCRIPT_SPLIT + 1150);
			if (sent >= SCRIPT_SPLIT + 300)
				hold_req = 1;
			if (!paused && sent >= SCRIPT_SPLIT + 700) begin
				paused = 1;
				drain();
			end
			if (phase != PH_HDR0) begin
				// out of step: feed noise until a header boundary comes round
				send_byte(8'($urandom_range(255)), FREE);
			end else begin
				make_frame();
				foreach (frame_bytes[i])
					send_byte(frame_bytes[i], FREE);
			end
		end
		calm = 0;

		while (phase != PH_HDR0 && sent < SCRIPT_SPLIT + RANDOM_ITEMS + 3000)
			send_byte(8'($urandom_range(255)), FREE);
		for (int i = SCRIPT_SPLIT; i < SCRIPT_ROWS; i++)
			send_byte(SCRIPT[i].data, SCRIPT[i].want);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_out.size() != 0)
			report_mismatch("results never delivered", pending_out.size(), 0);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#(CLK_PERIOD * 400000);
		$display("Test completed with failures");
		$finish;
	end

endmodule
